FILE: rtl/sgm_pkg.sv
// sgm_pkg: shared types and constants of the storage gas meter
// used by sgm_front, sgm_queue, sgm_back and storage_gas_meter
package sgm_pkg;

  localparam logic [4:0] REV_CONSTANTINOPLE = 5'd5;
  localparam logic [4:0] REV_PETERSBURG     = 5'd6;
  localparam logic [4:0] REV_ISTANBUL       = 5'd7;
  localparam logic [4:0] REV_BERLIN         = 5'd8;
  localparam logic [4:0] REV_LONDON         = 5'd9;
  localparam logic [4:0] REV_AMSTERDAM      = 5'd15;
  localparam logic [4:0] REV_TOP            = 5'd16;

  localparam logic [2:0] REG_REVISION   = 3'd0;
  localparam logic [2:0] REG_WARM_READ  = 3'd1;
  localparam logic [2:0] REG_COLD_READ  = 3'd2;
  localparam logic [2:0] REG_ATTACHED   = 3'd3;
  localparam logic [2:0] REG_INIT_RES   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOG    = 2'd1;
  localparam logic [1:0] ST_STATIC = 2'd2;

  localparam logic [3:0] UK_ASSIGNED  = 4'd0;
  localparam logic [3:0] UK_ADDED     = 4'd1;
  localparam logic [3:0] UK_DELETED   = 4'd2;
  localparam logic [3:0] UK_MODIFIED  = 4'd3;
  localparam logic [3:0] UK_DEL_ADD   = 4'd4;
  localparam logic [3:0] UK_MOD_DEL   = 4'd5;
  localparam logic [3:0] UK_DEL_REST  = 4'd6;
  localparam logic [3:0] UK_ADD_DEL   = 4'd7;
  localparam logic [3:0] UK_MOD_REST  = 4'd8;

  localparam logic signed [63:0] STATE_SET_GAS = 64'sd97920;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_FIXED,
    MODE_CHARGE,
    MODE_REFILL
  } mode_t;

  typedef struct packed {
    logic [4:0]  revision;
    logic [15:0] warm_read_cost;
    logic [15:0] cold_read_cost;
    logic        attached;
  } cfg_t;

  // classified instruction handed from front to back
  typedef struct packed {
    mode_t              mode;
    logic [1:0]         status;
    logic signed [63:0] gas;
    logic signed [63:0] sub;
    logic signed [15:0] refund;
    logic signed [17:0] sg;
  } work_t;

endpackage

FILE: rtl/sgm_front.sv
// sgm_front: input register and instruction classification
// depends on sgm_pkg; feeds sgm_queue
module sgm_front (
  input  logic                clk,
  input  logic                rst,
  input  sgm_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic signed [63:0]  gas_in,
  input  logic                static_mode,
  input  logic                slot_cold,
  input  logic [3:0]          update_kind,
  output logic                push,
  input  logic                q_full,
  output sgm_pkg::work_t      push_item
);

  logic               f_vld;
  logic               f_op;
  logic signed [63:0] f_gas;
  logic               f_static;
  logic               f_cold;
  logic [3:0]         f_kind;

  assign in_stall = f_vld && q_full;
  assign push     = f_vld && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (!in_stall) begin
      f_vld <= in_valid;
    end
    if (!in_stall && in_valid) begin
      f_op     <= operation;
      f_gas    <= gas_in;
      f_static <= static_mode;
      f_cold   <= slot_cold;
      f_kind   <= update_kind;
    end
  end

  logic [4:0]         rev;
  logic [3:0]         kind;
  logic               legacy;
  logic               ams;
  logic signed [31:0] warm_c, cold_c, warm, set_c, rst_c, clr, cost, refund, sg, cold_cost;
  logic signed [31:0] regular, extra, check;

  always_comb begin
    rev    = (cfg.revision > sgm_pkg::REV_TOP) ? sgm_pkg::REV_TOP : cfg.revision;
    kind   = (f_kind > sgm_pkg::UK_MOD_REST) ? sgm_pkg::UK_ASSIGNED : f_kind;
    legacy = (rev < sgm_pkg::REV_CONSTANTINOPLE) || (rev == sgm_pkg::REV_PETERSBURG);
    ams    = rev >= sgm_pkg::REV_AMSTERDAM;
    warm_c = $signed({16'd0, cfg.warm_read_cost});
    cold_c = $signed({16'd0, cfg.cold_read_cost});
    set_c  = 32'sd20000;
    rst_c  = 32'sd5000;
    clr    = 32'sd15000;
    if (rev < sgm_pkg::REV_ISTANBUL) begin
      warm = 32'sd200;
    end else if (rev == sgm_pkg::REV_ISTANBUL) begin
      warm = 32'sd800;
    end else begin
      warm  = warm_c;
      rst_c = 32'sd5000 - cold_c;
      if (rev >= sgm_pkg::REV_LONDON) clr = 32'sd4800;
    end
    cost   = warm;
    refund = '0;
    sg     = '0;
    if (ams) begin
      cost = 32'sd100;
      case (kind)
        sgm_pkg::UK_ADDED:    begin cost = 32'sd10100; sg = 32'sd97920; end
        sgm_pkg::UK_DELETED:  begin cost = 32'sd10100; refund = 32'sd12480; end
        sgm_pkg::UK_MODIFIED: cost = 32'sd10100;
        sgm_pkg::UK_DEL_ADD:  refund = -32'sd12480;
        sgm_pkg::UK_MOD_DEL:  refund = 32'sd12480;
        sgm_pkg::UK_DEL_REST: refund = 32'sd10000 - 32'sd12480;
        sgm_pkg::UK_ADD_DEL:  begin refund = 32'sd10000; sg = -32'sd97920; end
        sgm_pkg::UK_MOD_REST: refund = 32'sd10000;
        default: ;
      endcase
    end else if (legacy) begin
      case (kind)
        sgm_pkg::UK_ADDED, sgm_pkg::UK_DEL_ADD, sgm_pkg::UK_DEL_REST: cost = set_c;
        sgm_pkg::UK_DELETED, sgm_pkg::UK_MOD_DEL, sgm_pkg::UK_ADD_DEL: begin
          cost = rst_c; refund = clr;
        end
        default: cost = rst_c;
      endcase
    end else begin
      case (kind)
        sgm_pkg::UK_ADDED:    cost = set_c;
        sgm_pkg::UK_DELETED:  begin cost = rst_c; refund = clr; end
        sgm_pkg::UK_MODIFIED: cost = rst_c;
        sgm_pkg::UK_DEL_ADD:  refund = -clr;
        sgm_pkg::UK_MOD_DEL:  refund = clr;
        sgm_pkg::UK_DEL_REST: refund = rst_c - warm - clr;
        sgm_pkg::UK_ADD_DEL:  refund = set_c - warm;
        sgm_pkg::UK_MOD_REST: refund = rst_c - warm;
        default: ;
      endcase
    end
    cold_cost = '0;
    if (f_cold) cold_cost = ams ? 32'sd2900 : ((rev >= sgm_pkg::REV_BERLIN) ? cold_c : 32'sd0);
    regular = cost + cold_cost;
    extra   = (ams ? 32'sd3000 : cold_c) - warm_c;
    check   = f_cold ? 32'sd3000 : 32'sd2301;

    push_item.gas    = f_gas;
    push_item.status = sgm_pkg::ST_OK;
    push_item.refund = '0;
    push_item.sg     = '0;
    push_item.mode   = sgm_pkg::MODE_PLAIN;
    push_item.sub    = '0;
    if (!f_op) begin
      // a load with no cold surcharge never runs out of gas
      if (rev >= sgm_pkg::REV_BERLIN && f_cold) push_item.sub = 64'(extra);
      else push_item.mode = sgm_pkg::MODE_FIXED;
    end else if (f_static) begin
      push_item.mode   = sgm_pkg::MODE_FIXED;
      push_item.status = sgm_pkg::ST_STATIC;
    end else if (rev >= sgm_pkg::REV_ISTANBUL && !ams && f_gas <= 64'sd2300) begin
      push_item.mode   = sgm_pkg::MODE_FIXED;
      push_item.status = sgm_pkg::ST_OOG;
    end else if (ams && f_gas < 64'(check)) begin
      push_item.mode   = sgm_pkg::MODE_FIXED;
      push_item.status = sgm_pkg::ST_OOG;
      push_item.sub    = 64'(check);
    end else begin
      push_item.refund = refund[15:0];
      push_item.sg     = sg[17:0];
      if (sg > 0 && cfg.attached) begin
        push_item.mode = sgm_pkg::MODE_CHARGE;
        push_item.sub  = 64'(regular);
      end else if (sg < 0 && cfg.attached) begin
        push_item.mode = sgm_pkg::MODE_REFILL;
        push_item.sub  = 64'(regular);
      end else begin
        push_item.sub  = 64'(regular + sg);
      end
    end
  end

endmodule

FILE: rtl/sgm_queue.sv
// sgm_queue: short fifo of classified instructions between front and back
// depends on sgm_pkg
module sgm_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sgm_pkg::work_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output sgm_pkg::work_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sgm_pkg::work_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

FILE: rtl/sgm_back.sv
// sgm_back: gas charging, reservoir bookkeeping and output register
// depends on sgm_pkg; drains sgm_queue
module sgm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_load,
  input  logic [62:0]         res_value,
  input  logic                not_empty,
  input  sgm_pkg::work_t      item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          result_status,
  output logic signed [63:0]  gas_out,
  output logic signed [15:0]  refund_delta,
  output logic signed [17:0]  state_gas_delta
);

  logic signed [63:0] reservoir, state_from_gas;
  logic signed [63:0] reservoir_next, sfg_next;
  logic signed [63:0] from_res, to_gas, need, g;
  logic [1:0]         st;
  logic signed [15:0] rf;
  logic signed [17:0] sgo;

  assign pop = not_empty && (!out_valid || !out_stall);

  always_comb begin
    reservoir_next = reservoir;
    sfg_next       = state_from_gas;
    from_res = (reservoir < sgm_pkg::STATE_SET_GAS) ? reservoir : sgm_pkg::STATE_SET_GAS;
    to_gas   = (state_from_gas < sgm_pkg::STATE_SET_GAS) ? state_from_gas
                                                         : sgm_pkg::STATE_SET_GAS;
    need = item.sub + sgm_pkg::STATE_SET_GAS - from_res;
    g    = item.gas - item.sub;
    st   = sgm_pkg::ST_OK;
    rf   = item.refund;
    sgo  = item.sg;
    unique case (item.mode)
      sgm_pkg::MODE_FIXED: begin
        st = item.status;
      end
      sgm_pkg::MODE_PLAIN: begin
        if (g[63]) st = sgm_pkg::ST_OOG;
      end
      sgm_pkg::MODE_CHARGE: begin
        g = item.gas - need;
        if (item.gas < need) begin
          st = sgm_pkg::ST_OOG;
        end else begin
          reservoir_next = reservoir - from_res;
          sfg_next       = state_from_gas + sgm_pkg::STATE_SET_GAS - from_res;
        end
      end
      sgm_pkg::MODE_REFILL: begin
        if (g[63]) begin
          st = sgm_pkg::ST_OOG;
        end else begin
          g              = g + to_gas;
          sfg_next       = state_from_gas - to_gas;
          reservoir_next = reservoir + sgm_pkg::STATE_SET_GAS - to_gas;
        end
      end
      default: ;
    endcase
    if (st != sgm_pkg::ST_OK) begin
      rf  = '0;
      sgo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      reservoir      <= '0;
      state_from_gas <= '0;
    end else begin
      if (pop) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (res_load) begin
        reservoir <= $signed({1'b0, res_value});
      end else if (pop) begin
        reservoir <= reservoir_next;
      end
      if (pop) state_from_gas <= sfg_next;
    end
    if (pop) begin
      result_status   <= st;
      gas_out         <= g;
      refund_delta    <= rf;
      state_gas_delta <= sgo;
    end
  end

`ifndef NO_ASSERTIONS
  a_fail_no_delta: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_status != sgm_pkg::ST_OK |-> refund_delta == '0 && state_gas_delta == '0)
    else $error("failed instruction carries a delta");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_status != 2'd3)
    else $error("undefined status code");
  a_res_quiet: assert property (@(posedge clk) disable iff (rst)
    !pop && !$past(res_load) && !res_load |=> $stable(state_from_gas))
    else $error("state gas ledger moved without an instruction");
`endif

endmodule

FILE: rtl/storage_gas_meter.sv
// storage_gas_meter: top level of the storage load/store gas meter
// depends on sgm_pkg, sgm_front, sgm_queue, sgm_back
//
// usage
//   input channel: in_valid/in_stall with operation, gas_in, static_mode,
//   slot_cold and update_kind; a beat moves when in_valid is high and
//   in_stall low. each beat yields exactly one result beat.
//   output channel: out_valid/out_stall with result_status, gas_out,
//   refund_delta and state_gas_delta; held steady while out_stall is high.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no beat is in flight. writing initial_reservoir
//   also loads the reservoir.
//   path: each beat passes the input register, one queue slot and the output
//   register. throughput: one beat per cycle while out_stall is low; the
//   reservoir is updated in the back end as each result is registered.
//   reset: rst, synchronous; registers return to their defaults (revision 15,
//   warm 100, cold 2100, no reservoir) and the queue empties.
//   stall: a stalled output backs up into the queue of DEPTH entries, then
//   into the input register, after which in_stall rises.
module storage_gas_meter #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [63:0] gas_in,
  input  logic               static_mode,
  input  logic               slot_cold,
  input  logic [3:0]         update_kind,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_status,
  output logic signed [63:0] gas_out,
  output logic signed [15:0] refund_delta,
  output logic signed [17:0] state_gas_delta
);

  sgm_pkg::cfg_t  cfg;
  logic [62:0]    init_res;
  logic           res_load;
  logic           push, q_full, pop, not_empty;
  sgm_pkg::work_t push_item, pop_item;

  assign cfg_ready = 1'b1;
  assign res_load  = cfg_valid && cfg_index == sgm_pkg::REG_INIT_RES;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.revision       <= 5'd15;
      cfg.warm_read_cost <= 16'd100;
      cfg.cold_read_cost <= 16'd2100;
      cfg.attached       <= 1'b0;
      init_res           <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sgm_pkg::REG_REVISION:  cfg.revision       <= cfg_data[4:0];
        sgm_pkg::REG_WARM_READ: cfg.warm_read_cost <= cfg_data[15:0];
        sgm_pkg::REG_COLD_READ: cfg.cold_read_cost <= cfg_data[15:0];
        sgm_pkg::REG_ATTACHED:  cfg.attached       <= cfg_data[0];
        sgm_pkg::REG_INIT_RES:  init_res           <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  sgm_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_stall, .operation, .gas_in, .static_mode,
    .slot_cold, .update_kind, .push, .q_full, .push_item
  );

  sgm_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst, .push, .push_item, .full(q_full), .pop, .not_empty, .pop_item
  );

  sgm_back u_back (
    .clk, .rst, .res_load, .res_value(cfg_data[62:0]), .not_empty, .item(pop_item),
    .pop, .out_valid, .out_stall, .result_status, .gas_out, .refund_delta,
    .state_gas_delta
  );

`ifndef NO_ASSERTIONS
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");
  a_init_mirror: assert property (@(posedge clk) disable iff (rst)
    res_load |=> init_res == $past(cfg_data[62:0]))
    else $error("initial reservoir register not loaded");
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with queue space");
`endif

endmodule

FILE: sim/tb_storage_gas_meter.sv
// tb_storage_gas_meter: self-checking testbench of the storage gas meter
// depends on sgm_pkg and storage_gas_meter; predicts every result beat from
// the instruction stream and the register settings, then compares field by field
module tb_storage_gas_meter;

  typedef struct {
    logic        op;
    logic [63:0] gas;
    logic        stat;
    logic        cold;
    logic [3:0]  kind;
  } instr_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] gas;
    logic [15:0] refund;
    logic [17:0] sg;
  } charge_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic operation = 1'b0;
  logic signed [63:0] gas_in = '0;
  logic static_mode = 1'b0;
  logic slot_cold = 1'b0;
  logic [3:0] update_kind = '0;
  logic out_stall = 1'b0;
  logic cfg_ready, in_stall, out_valid;
  logic [1:0] result_status;
  logic signed [63:0] gas_out;
  logic signed [15:0] refund_delta;
  logic signed [17:0] state_gas_delta;

  storage_gas_meter u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .gas_in(gas_in), .static_mode(static_mode), .slot_cold(slot_cold),
    .update_kind(update_kind),
    .out_valid(out_valid), .out_stall(out_stall), .result_status(result_status),
    .gas_out(gas_out), .refund_delta(refund_delta), .state_gas_delta(state_gas_delta)
  );

  always #2 clk = ~clk;

  // predictor copy of registers and running totals
  logic [4:0]  m_rev;
  logic [15:0] m_warm, m_coldc;
  logic        m_att;
  logic [63:0] m_res, m_from_gas, m_from_res, m_net, m_refund_total;

  instr_t  pending_instrs[$];
  charge_t expected_charges[$];
  int cycles = 0, mismatches = 0, checked = 0, in_sent = 0;
  int quiet = 0;          // cycles left with no idling
  int hold = 0;           // long receiver hold-off
  bit press_req = 1'b0;
  logic in_held = 1'b0;   // input beat offered but not taken at the last edge

  function automatic longint smin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic charge_t mk(logic [1:0] st, logic [63:0] g, longint rf, longint s);
    charge_t c;
    c.status = st; c.gas = g; c.refund = rf[15:0]; c.sg = s[17:0];
    return c;
  endfunction

  function automatic charge_t meter_instr(instr_t it);
    logic [4:0] rev;
    logic [63:0] g;
    longint cw, rf, sg, cc, reg_cost, warm, set, rst_c, clr, chk, fr, need, rfl, tg, tr;
    logic [3:0] k;
    bit legacy;
    rev = m_rev > sgm_pkg::REV_TOP ? sgm_pkg::REV_TOP : m_rev;
    g = it.gas;
    k = it.kind > sgm_pkg::UK_MOD_REST ? sgm_pkg::UK_ASSIGNED : it.kind;
    sg = 0; cc = 0; rf = 0; cw = 0;
    if (!it.op) begin
      if (rev >= sgm_pkg::REV_BERLIN && it.cold) begin
        g = g - ((rev >= sgm_pkg::REV_AMSTERDAM ? 64'd3000 : 64'(m_coldc)) - 64'(m_warm));
        if (g[63]) return mk(sgm_pkg::ST_OOG, g, 0, 0);
      end
      return mk(sgm_pkg::ST_OK, g, 0, 0);
    end
    if (it.stat) return mk(sgm_pkg::ST_STATIC, g, 0, 0);
    if (rev >= sgm_pkg::REV_ISTANBUL && rev < sgm_pkg::REV_AMSTERDAM && $signed(g) <= 2300)
      return mk(sgm_pkg::ST_OOG, g, 0, 0);
    if (rev >= sgm_pkg::REV_AMSTERDAM) begin
      chk = it.cold ? 3000 : 2301;
      if ($signed(g) < chk) return mk(sgm_pkg::ST_OOG, g - chk, 0, 0);
      if (it.cold) cc = 2900;
      cw = 100;
      case (k)
        sgm_pkg::UK_ADDED:     begin cw = 10100; sg = 97920; end
        sgm_pkg::UK_DELETED:   begin cw = 10100; rf = 12480; end
        sgm_pkg::UK_MODIFIED:  cw = 10100;
        sgm_pkg::UK_DEL_ADD:   rf = -12480;
        sgm_pkg::UK_MOD_DEL:   rf = 12480;
        sgm_pkg::UK_DEL_REST:  rf = 10000 - 12480;
        sgm_pkg::UK_ADD_DEL:   begin rf = 10000; sg = -97920; end
        sgm_pkg::UK_MOD_REST:  rf = 10000;
        default: ;
      endcase
    end else begin
      if (rev >= sgm_pkg::REV_BERLIN && it.cold) cc = m_coldc;
      set = 20000; rst_c = 5000; clr = 15000;
      legacy = rev < sgm_pkg::REV_CONSTANTINOPLE || rev == sgm_pkg::REV_PETERSBURG;
      if (rev < sgm_pkg::REV_ISTANBUL) warm = 200;
      else if (rev == sgm_pkg::REV_ISTANBUL) warm = 800;
      else begin
        warm = m_warm; rst_c = 5000 - longint'(m_coldc);
        if (rev >= sgm_pkg::REV_LONDON) clr = 4800;
      end
      if (legacy) begin
        if (k == sgm_pkg::UK_ADDED || k == sgm_pkg::UK_DEL_ADD || k == sgm_pkg::UK_DEL_REST)
          cw = set;
        else if (k == sgm_pkg::UK_DELETED || k == sgm_pkg::UK_MOD_DEL ||
                 k == sgm_pkg::UK_ADD_DEL) begin
          cw = rst_c; rf = clr;
        end else cw = rst_c;
      end else begin
        cw = warm;
        case (k)
          sgm_pkg::UK_ADDED:    cw = set;
          sgm_pkg::UK_DELETED:  begin cw = rst_c; rf = clr; end
          sgm_pkg::UK_MODIFIED: cw = rst_c;
          sgm_pkg::UK_DEL_ADD:  rf = -clr;
          sgm_pkg::UK_MOD_DEL:  rf = clr;
          sgm_pkg::UK_DEL_REST: rf = rst_c - warm - clr;
          sgm_pkg::UK_ADD_DEL:  rf = set - warm;
          sgm_pkg::UK_MOD_REST: rf = rst_c - warm;
          default: ;
        endcase
      end
    end
    reg_cost = cw + cc;
    if (sg > 0 && m_att) begin
      fr = smin(sg, $signed(m_res));
      need = reg_cost + (sg - fr);
      if ($signed(g) < need) return mk(sgm_pkg::ST_OOG, g - need, 0, 0);
      g = g - need;
      m_res = m_res - fr;
      m_from_gas = m_from_gas + (sg - fr);
      m_from_res = m_from_res + fr;
      m_net = m_net + sg;
    end else if (sg < 0 && m_att) begin
      rfl = -sg;
      g = g - reg_cost;
      if (g[63]) return mk(sgm_pkg::ST_OOG, g, 0, 0);
      tg = smin(rfl, $signed(m_from_gas));
      g = g + tg;
      m_from_gas = m_from_gas - tg;
      tr = rfl - tg;
      m_res = m_res + tr;
      m_from_res = m_from_res - smin(tr, $signed(m_from_res));
      m_net = m_net - rfl;
    end else begin
      g = g - (reg_cost + sg);
      if (g[63]) return mk(sgm_pkg::ST_OOG, g, 0, 0);
    end
    m_refund_total = m_refund_total + {{48{rf[15]}}, rf[15:0]};
    return mk(sgm_pkg::ST_OK, g, rf, sg);
  endfunction

  // remember whether the offered beat was refused at this edge
  always @(posedge clk) begin
    in_held <= in_valid && in_stall;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_held) begin
        if (pending_instrs.size() > 0 && (quiet > 0 || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          operation <= pending_instrs[0].op;
          gas_in <= pending_instrs[0].gas;
          static_mode <= pending_instrs[0].stat;
          slot_cold <= pending_instrs[0].cold;
          update_kind <= pending_instrs[0].kind;
          expected_charges.push_back(meter_instr(pending_instrs.pop_front()));
          in_sent++;
        end else in_valid <= 1'b0;
      end
      if (quiet > 0) quiet--;
    end
  end

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (press_req && hold == 0) begin
      hold = 150;
      press_req = 1'b0;
    end
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else out_stall <= !rst && quiet == 0 && $urandom_range(99) < 7;
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_charges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d gas %0d",
                                       result_status, gas_out);
      end else begin
        charge_t e;
        e = expected_charges.pop_front();
        checked++;
        if (e.status !== result_status || e.gas !== gas_out ||
            e.refund !== refund_delta || e.sg !== state_gas_delta) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d gas %0d rf %0d sg %0d, got st %0d gas %0d rf %0d sg %0d",
                     e.status, $signed(e.gas), $signed(e.refund), $signed(e.sg),
                     result_status, gas_out, refund_delta, state_gas_delta);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sgm_pkg::REG_REVISION:  m_rev = val[4:0];
      sgm_pkg::REG_WARM_READ: m_warm = val[15:0];
      sgm_pkg::REG_COLD_READ: m_coldc = val[15:0];
      sgm_pkg::REG_ATTACHED:  m_att = val[0];
      sgm_pkg::REG_INIT_RES:  m_res = {1'b0, val[62:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_instrs.size() > 0 || expected_charges.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_instr(logic op, logic [63:0] g, logic st, logic cd, logic [3:0] k);
    instr_t it;
    it.op = op; it.gas = g; it.stat = st; it.cold = cd; it.kind = k;
    pending_instrs.push_back(it);
  endtask

  function automatic logic [63:0] rand_gas();
    case ($urandom_range(5))
      0: return {$urandom(), $urandom()};
      1: return 64'($urandom_range(4000));
      2: return 64'($urandom_range(120000));
      3: return 64'd2300 + $urandom_range(2);
      default: return 64'($urandom_range(300000)) + 64'd2000;
    endcase
  endfunction

  task automatic random_batch(int n);
    repeat (n)
      add_instr($urandom_range(99) < 75, rand_gas(), $urandom_range(99) < 10,
                $urandom_range(1), $urandom_range(99) < 6 ? 4'($urandom_range(15))
                                                          : 4'($urandom_range(8)));
  endtask

  initial begin
    m_rev = 5'd15; m_warm = 16'd100; m_coldc = 16'd2100; m_att = 1'b0;
    m_res = '0; m_from_gas = '0; m_from_res = '0; m_net = '0; m_refund_total = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, every update kind code, warm and cold alternating, field extremes
    for (int k = 0; k < 16; k++) add_instr(1'b1, 64'd50000, 1'b0, k[0], 4'(k));
    add_instr(1'b0, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 4'hf);
    add_instr(1'b0, 64'd100, 1'b0, 1'b1, sgm_pkg::UK_ASSIGNED);
    add_instr(1'b0, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0, sgm_pkg::UK_ASSIGNED);
    add_instr(1'b0, 64'hffff_ffff_ffff_fff0, 1'b0, 1'b0, sgm_pkg::UK_ASSIGNED);
    add_instr(1'b1, 64'd100, 1'b1, 1'b0, sgm_pkg::UK_ADDED);
    add_instr(1'b1, 64'd2999, 1'b0, 1'b1, sgm_pkg::UK_ADDED);
    add_instr(1'b1, 64'd2300, 1'b0, 1'b0, sgm_pkg::UK_ADDED);
    add_instr(1'b1, 64'd10000, 1'b0, 1'b0, sgm_pkg::UK_ADDED);
    add_instr(1'b1, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, sgm_pkg::UK_MODIFIED);
    drain();

    // reservoir, with a long receiver hold-off while items keep coming
    write_reg(sgm_pkg::REG_ATTACHED, 64'd1);
    write_reg(sgm_pkg::REG_INIT_RES, 64'hffff_ffff_ffff_ffff);
    write_reg(sgm_pkg::REG_INIT_RES, 64'd150000);
    quiet = 200;
    press_req = 1'b1;
    repeat (40) begin
      add_instr(1'b1, 64'd400000, 1'b0, $urandom_range(1), sgm_pkg::UK_ADDED);
      add_instr(1'b1, 64'd400000, 1'b0, $urandom_range(1), sgm_pkg::UK_ADD_DEL);
    end
    random_batch(40);
    drain();

    // sweep revisions including extremes and out-of-range value
    for (int p = 0; p < 9; p++) begin
      automatic logic [4:0] revs[9] = '{5'd0, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd16, 5'd31,
                                        5'd15};
      write_reg(sgm_pkg::REG_REVISION, {$urandom(), $urandom()} & ~64'h1f | 64'(revs[p]));
      write_reg(sgm_pkg::REG_WARM_READ,
                p == 0 ? 64'd0 : p == 1 ? 64'hffff : 64'($urandom_range(3000)));
      write_reg(sgm_pkg::REG_COLD_READ,
                p == 0 ? 64'hffff : p == 1 ? 64'd0 : 64'($urandom_range(5000)));
      write_reg(sgm_pkg::REG_ATTACHED, 64'($urandom_range(1)));
      write_reg(sgm_pkg::REG_INIT_RES,
                p == 2 ? 64'h7fff_ffff_ffff_ffff : 64'($urandom_range(200000)));
      random_batch(p == 8 ? 60 : 30);
      drain();
    end

    $display("covered %0d instructions, %0d results checked over nine register settings",
             in_sent, checked);
    if (mismatches == 0 && expected_charges.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
